### hdl/fcou_pkg.sv
`default_nettype none
package fcou_pkg;
  localparam int MOUSE_BITS_DEF = 12;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_W = 32;
  localparam int VEC_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_FLY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND = 2'd3;
  localparam logic [0:0] CMD_MOVE = 1'b0;
  localparam logic [0:0] CMD_LOOK = 1'b1;
  localparam logic [2:0] DIR_FWD = 3'd0;
  localparam logic [2:0] DIR_BACK = 3'd1;
  localparam logic [2:0] DIR_LEFT = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP = 3'd4;
  localparam logic [2:0] DIR_DOWN = 3'd5;
  localparam logic [14:0] POLY_A = 15'd25736;
  localparam logic [13:0] POLY_B = 14'd10512;
  localparam logic [10:0] POLY_C = 11'd1160;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_SIN, ST_VEC, ST_VEL, ST_MOVE, ST_DONE
  } state_t;

  // serial multiplier control
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage
`default_nettype wire

### hdl/fcou_if.sv
`default_nettype none
interface fcou_in_if #(parameter int MOUSE_BITS = 12);
  logic valid;
  logic ready;
  logic [0:0] command;
  logic [2:0] move_dir;
  logic [15:0] delta_time;
  logic [MOUSE_BITS-1:0] mouse_x;
  logic [MOUSE_BITS-1:0] mouse_y;
  modport source(output valid, command, move_dir, delta_time, mouse_x, mouse_y, input ready);
  modport sink(input valid, command, move_dir, delta_time, mouse_x, mouse_y, output ready);
endinterface

interface fcou_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  modport source(output valid, pos_x, pos_y, pos_z, view_x, view_y, view_z,
                 up_x, up_y, up_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, view_x, view_y, view_z,
               up_x, up_y, up_z, output ready);
endinterface
`default_nettype wire

### hdl/fcou_mul.sv
`default_nettype none
// Signed shift-add multiplier, one multiplier bit per cycle.
// Product is a*b; done pulses in the cycle after the last bit.
module fcou_mul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic done,
  output logic signed [AW+BW-1:0] prod
);
  import fcou_pkg::*;
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [BW-1:0] mplr_r, mplr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplr_nxt = mplr_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = (AW + BW)'(a);
      mplr_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top bit of a two's complement multiplier carries negative weight
      if (mplr_r[0]) begin
        if (cnt_r == CW'(BW - 1)) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplr_nxt = mplr_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplr_r <= mplr_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

### hdl/fly_camera_orientation_update.sv
`default_nettype none
// Every product goes through one shared serial multiplier, one bit per cycle; it sets the rate.
// Throughput: one word at a time; the next word is taken once the result word is accepted.
// Reset (rst_n low, synchronous) restores registers, position (5.0, 0.5, 10.0),
// yaw of minus ninety degrees, pitch zero and mouse history (400, 300).
module fly_camera_orientation_update #(
  parameter int MOUSE_BITS = fcou_pkg::MOUSE_BITS_DEF,
  parameter int ANGLE_BITS = fcou_pkg::ANGLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fcou_in_if.sink in_ch,
  fcou_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [fcou_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fcou_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcou_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int MB = MOUSE_BITS;
  localparam logic [AB-1:0] ANG_MASK = {AB{1'b1}};
  localparam longint PL = (89 * (64'd1 << AB) + 180) / 360;
  localparam logic signed [AB:0] PITCH_LIM = (AB + 1)'(PL);
  localparam logic [AB-1:0] YAW_RST = AB'(3) << (AB - 2);
  localparam logic [MB-1:0] MX_RST = MB'(400);
  localparam logic [MB-1:0] MY_RST = MB'(300);
  localparam int MA = 32;
  localparam int MBW = 16;
  localparam int PW = MA + MBW;

  // configuration
  logic signed [15:0] speed_r;
  logic [11:0] gain_r;
  logic free_r;
  logic signed [31:0] ground_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 16'sd1280;
      gain_r <= 12'd18;
      free_r <= 1'b0;
      ground_r <= 32'sd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVE_SPEED: speed_r <= cfg_data[15:0];
        REG_LOOK_GAIN: gain_r <= cfg_data[11:0];
        REG_FREE_FLY: free_r <= cfg_data[0];
        REG_GROUND: ground_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier. Each op is one micro step: load operands, wait done.
  logic mstart;
  logic signed [MA-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic mdone;
  logic signed [PW-1:0] mprod;
  fcou_mul #(.AW(MA), .BW(MBW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .prod(mprod)
  );

  // architectural state
  logic [31:0] pos_r [3];
  logic [AB-1:0] yaw_r;
  logic signed [AB:0] pitch_r;
  logic [MB-1:0] lmx_r, lmy_r;
  logic seen_r;

  // captured word
  logic cmd_r;
  logic [2:0] dir_r;
  logic [15:0] dt_r;
  logic [MB-1:0] mx_r, my_r;

  // sine unit scratch: 4 sines, each 4 multiplies; then vector products
  logic signed [15:0] trig_r [4];   // sy, cy, sp, cp
  logic signed [15:0] view_r [3], up_r [3];
  logic signed [31:0] vel_r;
  logic [15:0] z_r, z2_r, t_r;
  logic [1:0] quad_r;
  logic signed [AB+MB+13:0] dx_r;

  state_t st_r, st_nxt;
  logic [4:0] step_r, step_nxt;   // micro step within a phase
  logic wait_r;                  // multiplier running
  logic out_v_r;

  // 16-bit turn value of angle index
  function automatic logic [15:0] turn16(input logic [AB-1:0] a);
    if (AB >= 16) turn16 = 16'(a >> (AB - 16));
    else turn16 = 16'({a, 16'd0} >> AB);
  endfunction

  logic [15:0] ang_u;
  always_comb begin
    case (step_r[4:3])
      2'd0: ang_u = turn16(yaw_r);
      2'd1: ang_u = turn16(yaw_r) + 16'd16384;
      2'd2: ang_u = turn16(pitch_r[AB-1:0]);
      default: ang_u = turn16(pitch_r[AB-1:0]) + 16'd16384;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid && !out_v_r) st_nxt = (in_ch.command == CMD_LOOK) ? ST_LOOK : ST_SIN;
      ST_LOOK: if (mdone && step_r[0]) st_nxt = ST_SIN;
      ST_SIN: if (mdone && step_r == 5'd27) st_nxt = ST_VEC;
      ST_VEC: if (mdone && step_r == 5'd3) st_nxt = cmd_r ? ST_DONE : ST_VEL;
      ST_VEL: if (mdone) st_nxt = ST_MOVE;
      ST_MOVE: if (mdone && step_r == 5'd2) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // multiplier operand select
  logic signed [15:0] vsel;
  logic vneg, vnone;
  always_comb begin
    vneg = 1'b0;
    vnone = 1'b0;
    case (dir_r)
      DIR_FWD, DIR_BACK: vsel = view_r[step_r[1:0]];
      DIR_LEFT, DIR_RIGHT:
        case (step_r[1:0])
          2'd0: vsel = -trig_r[0];
          2'd1: vsel = 16'sd0;
          default: vsel = trig_r[1];
        endcase
      DIR_UP, DIR_DOWN: vsel = up_r[step_r[1:0]];
      default: begin
        vsel = 16'sd0;
        vnone = 1'b1;
      end
    endcase
    if (dir_r == DIR_BACK || dir_r == DIR_LEFT || dir_r == DIR_DOWN) vneg = 1'b1;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      ST_LOOK: begin
        ma = step_r[0] ? MA'($signed({1'b0, lmy_r}) - $signed({1'b0, my_r}))
                       : MA'($signed({1'b0, mx_r}) - $signed({1'b0, lmx_r}));
        mb = MBW'($signed({1'b0, gain_r}));
      end
      ST_SIN:
        case (step_r[2:0])
          3'd0: begin ma = MA'(z_r); mb = z_r; end
          3'd1: begin ma = MA'(z2_r); mb = MBW'(POLY_C); end
          3'd2: begin ma = MA'(z2_r); mb = t_r; end
          default: begin ma = MA'(z_r); mb = t_r; end
        endcase
      ST_VEC:
        case (step_r[1:0])
          2'd0: begin ma = MA'(trig_r[1]); mb = trig_r[3]; end
          2'd1: begin ma = MA'(trig_r[0]); mb = trig_r[3]; end
          2'd2: begin ma = MA'(trig_r[1]); mb = trig_r[2]; end
          default: begin ma = MA'(trig_r[0]); mb = trig_r[2]; end
        endcase
      ST_VEL: begin ma = MA'(speed_r); mb = dt_r; end
      ST_MOVE: begin ma = vel_r; mb = vsel; end
      default: ;
    endcase
  end

  // vel for ST_VEL: dt unsigned, so multiply extends via 16-bit; handle sign of dt
  logic signed [PW-1:0] vel_full;
  assign vel_full = mprod + (dt_r[15] ? (PW'(speed_r) <<< 16) : '0);

  logic signed [AB+MB+14:0] np;
  logic [15:0] s_val;
  assign np = (AB + MB + 15)'(pitch_r) + (AB + MB + 15)'(mprod);
  assign s_val = 16'(mprod >>> 14);

  assign mstart = (st_r != ST_IDLE) && (st_r != ST_DONE) && !wait_r
                  && !(st_r == ST_SIN && step_r[2:0] == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      step_r <= '0;
      wait_r <= 1'b0;
      out_v_r <= 1'b0;
      pos_r[0] <= 32'd327680;
      pos_r[1] <= 32'd32768;
      pos_r[2] <= 32'd655360;
      yaw_r <= YAW_RST & ANG_MASK;
      pitch_r <= '0;
      lmx_r <= MX_RST;
      lmy_r <= MY_RST;
      seen_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (mstart) wait_r <= 1'b1;
      if (mdone) wait_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          // a move word opens on the fold cycle of the sine phase
          step_r <= (in_ch.command == CMD_LOOK) ? 5'd0 : 5'd4;
          if (in_ch.valid && !out_v_r) begin
            cmd_r <= in_ch.command;
            dir_r <= in_ch.move_dir;
            dt_r <= in_ch.delta_time;
            mx_r <= in_ch.mouse_x;
            my_r <= in_ch.mouse_y;
            if (in_ch.command == CMD_LOOK && !seen_r) begin
              lmx_r <= in_ch.mouse_x;
              lmy_r <= in_ch.mouse_y;
              seen_r <= 1'b1;
            end
          end
        end
        ST_LOOK: if (mdone) begin
          if (!step_r[0]) begin
            dx_r <= (AB + MB + 14)'(mprod);
            step_r <= 5'd1;
          end else begin
            yaw_r <= (yaw_r + AB'(dx_r)) & ANG_MASK;
            if (np > (AB + MB + 15)'(PITCH_LIM)) pitch_r <= PITCH_LIM;
            else if (np < -(AB + MB + 15)'(PITCH_LIM)) pitch_r <= -PITCH_LIM;
            else pitch_r <= (AB + 1)'(np);
            lmx_r <= mx_r;
            lmy_r <= my_r;
            step_r <= 5'd4;
          end
        end
        ST_SIN: begin
          // step[2:0]=4 is a setup cycle that folds the angle
          if (step_r[2:0] == 3'd4 && !wait_r) begin
            quad_r <= ang_u[15:14];
            z_r <= ang_u[14] ? 16'd16384 - {2'b0, ang_u[13:0]} : {2'b0, ang_u[13:0]};
            step_r <= {step_r[4:3], 3'd0};
          end else if (mdone) begin
            case (step_r[2:0])
              3'd0: z2_r <= 16'(mprod >>> 14);
              3'd1: t_r <= 16'(POLY_B) - 16'(mprod >>> 14);
              3'd2: t_r <= 16'(POLY_A) - 16'(mprod >>> 14);
              default: trig_r[step_r[4:3]] <= quad_r[1] ? -s_val : s_val;
            endcase
            if (step_r == 5'd27) step_r <= 5'd0;
            else if (step_r[2:0] == 3'd3) step_r <= {step_r[4:3] + 2'd1, 3'd4};
            else step_r <= step_r + 5'd1;
          end
        end
        ST_VEC: if (mdone) begin
          case (step_r[1:0])
            2'd0: view_r[0] <= s_val;
            2'd1: view_r[2] <= s_val;
            2'd2: up_r[0] <= -s_val;
            default: up_r[2] <= -s_val;
          endcase
          view_r[1] <= trig_r[2];
          up_r[1] <= trig_r[3];
          step_r <= (step_r[1:0] == 2'd3) ? 5'd0 : step_r + 5'd1;
        end
        ST_VEL: if (mdone) vel_r <= 32'(vel_full >>> 8);
        ST_MOVE: if (mdone) begin
          if (!vnone) begin
            if (vneg) pos_r[step_r[1:0]] <= pos_r[step_r[1:0]] - 32'(mprod >>> 14);
            else pos_r[step_r[1:0]] <= pos_r[step_r[1:0]] + 32'(mprod >>> 14);
          end
          step_r <= step_r + 5'd1;
        end
        ST_DONE: begin
          if (!cmd_r && !free_r) pos_r[1] <= ground_r;
          out_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (st_r == ST_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.pos_x = pos_r[0];
  assign out_ch.pos_y = pos_r[1];
  assign out_ch.pos_z = pos_r[2];
  assign out_ch.view_x = view_r[0];
  assign out_ch.view_y = view_r[1];
  assign out_ch.view_z = view_r[2];
  assign out_ch.up_x = up_r[0];
  assign out_ch.up_y = up_r[1];
  assign out_ch.up_z = up_r[2];

  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= PITCH_LIM) && (pitch_r >= -PITCH_LIM)) else $error("pitch out of range");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_ch.ready) else $error("accept while result pending");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> out_v_r) else $error("result lost");
endmodule
`default_nettype wire

### test/fly_camera_orientation_update_test.sv
module fly_camera_orientation_update_test;
  import fcou_pkg::*;

  // one result word of the camera
  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] vx, vy, vz, ux, uy, uz;
  } cam_word_t;

  // Camera predictor plus queue of pending camera words.
  class camera_scoreboard;
    logic signed [15:0] speed;
    logic [11:0] gain;
    logic fly;
    logic signed [31:0] ground;
    logic [31:0] pos [3];
    logic [15:0] yaw;
    int pitch;
    logic [11:0] last_x, last_y;
    bit seen_look;
    cam_word_t pending[$];
    int errors;
    int matched;

    function void reset_state();
      speed = 16'sd1280; gain = 12'd18; fly = 1'b0; ground = 32'sd32768;
      pos[0] = 32'd327680; pos[1] = 32'd32768; pos[2] = 32'd655360;
      yaw = 16'd49152; pitch = 0; last_x = 12'd400; last_y = 12'd300;
      seen_look = 0; pending.delete(); errors = 0; matched = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        REG_MOVE_SPEED: speed = d[15:0];
        REG_LOOK_GAIN:  gain = d[11:0];
        REG_FREE_FLY:   fly = d[0];
        default:        ground = d;
      endcase
    endfunction

    // polynomial sine over a 16-bit turn, Q14 result
    function int sine14(logic [15:0] u);
      logic [1:0] quad;
      longint z, z2, t, s;
      quad = u[15:14];
      z = u[13:0];
      if (quad[0]) z = 16384 - z;
      z2 = (z * z) >> 14;
      t = 10512 - ((z2 * 1160) >> 14);
      t = 25736 - ((z2 * t) >> 14);
      s = (z * t) >> 14;
      return quad[1] ? -int'(s) : int'(s);
    endfunction

    // floor shift by 14 via arithmetic shift of 64-bit product
    function longint mul14(longint a, longint b);
      return (a * b) >>> 14;
    endfunction

    function void note_word(logic cmd, logic [2:0] dir, logic [15:0] dt,
                            logic [11:0] mx, logic [11:0] my);
      longint dx, dy, np, vel, d;
      int cy, sy, cp, sp;
      longint vw[3], rt[3], uv[3];
      logic [15:0] pu;
      bit neg, has;
      longint vec[3];
      cam_word_t w;
      if (cmd == CMD_LOOK) begin
        if (!seen_look) begin
          last_x = mx; last_y = my; seen_look = 1;
        end
        dx = (longint'(mx) - longint'(last_x)) * longint'(gain);
        dy = (longint'(last_y) - longint'(my)) * longint'(gain);
        last_x = mx; last_y = my;
        yaw = yaw + dx[15:0];
        np = pitch + dy;
        if (np > 16202) np = 16202;
        if (np < -16202) np = -16202;
        pitch = int'(np);
      end
      pu = pitch[15:0];
      sy = sine14(yaw); cy = sine14(yaw + 16'd16384);
      sp = sine14(pu); cp = sine14(pu + 16'd16384);
      vw[0] = mul14(cy, cp); vw[1] = sp; vw[2] = mul14(sy, cp);
      rt[0] = -sy; rt[1] = 0; rt[2] = cy;
      uv[0] = -mul14(cy, sp); uv[1] = cp; uv[2] = -mul14(sy, sp);
      if (cmd == CMD_MOVE) begin
        vel = (longint'(speed) * longint'(dt)) >>> 8;
        has = 1; neg = 0;
        case (dir)
          DIR_FWD:   vec = vw;
          DIR_BACK:  begin vec = vw; neg = 1; end
          DIR_LEFT:  begin vec = rt; neg = 1; end
          DIR_RIGHT: vec = rt;
          DIR_UP:    vec = uv;
          DIR_DOWN:  begin vec = uv; neg = 1; end
          default:   has = 0;
        endcase
        if (has)
          for (int k = 0; k < 3; k++) begin
            d = (vel * vec[k]) >>> 14;
            pos[k] = neg ? pos[k] - d[31:0] : pos[k] + d[31:0];
          end
        if (!fly) pos[1] = ground;
      end
      w.px = pos[0]; w.py = pos[1]; w.pz = pos[2];
      w.vx = vw[0][15:0]; w.vy = vw[1][15:0]; w.vz = vw[2][15:0];
      w.ux = uv[0][15:0]; w.uy = uv[1][15:0]; w.uz = uv[2][15:0];
      pending.push_back(w);
    endfunction

    function void check_word(cam_word_t a);
      cam_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected camera word pos=(%0d,%0d,%0d)", a.px, a.py, a.pz);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (a.px !== e.px) begin $error("pos_x exp %0d got %0d", e.px, a.px); errors++; end
      if (a.py !== e.py) begin $error("pos_y exp %0d got %0d", e.py, a.py); errors++; end
      if (a.pz !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, a.pz); errors++; end
      if (a.vx !== e.vx) begin $error("view_x exp %0d got %0d", e.vx, a.vx); errors++; end
      if (a.vy !== e.vy) begin $error("view_y exp %0d got %0d", e.vy, a.vy); errors++; end
      if (a.vz !== e.vz) begin $error("view_z exp %0d got %0d", e.vz, a.vz); errors++; end
      if (a.ux !== e.ux) begin $error("up_x exp %0d got %0d", e.ux, a.ux); errors++; end
      if (a.uy !== e.uy) begin $error("up_y exp %0d got %0d", e.uy, a.uy); errors++; end
      if (a.uz !== e.uz) begin $error("up_z exp %0d got %0d", e.uz, a.uz); errors++; end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fcou_in_if #(.MOUSE_BITS(12)) in_ch ();
  fcou_out_if out_ch ();

  fly_camera_orientation_update u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  camera_scoreboard board;
  longint cycle_count = 0;
  bit hold_off = 0;        // long receiver stall request
  int looks_sent = 0, moves_sent = 0;

  // Hold inputs known from time zero.
  initial begin
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.move_dir = '0;
    in_ch.delta_time = '0; in_ch.mouse_x = '0; in_ch.mouse_y = '0;
    out_ch.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Receiver: random stalls; a long hold-off when asked.
  initial begin
    cam_word_t w;
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        w.px = out_ch.pos_x; w.py = out_ch.pos_y; w.pz = out_ch.pos_z;
        w.vx = out_ch.view_x; w.vy = out_ch.view_y; w.vz = out_ch.view_z;
        w.ux = out_ch.up_x; w.uy = out_ch.up_y; w.uz = out_ch.up_z;
        board.check_word(w);
      end
    end
  end

  // Cycle limit: ~1700 words plus stalls, taken several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one word; advance once it is accepted, then note it in the predictor.
  task automatic send_word(logic cmd, logic [2:0] dir, logic [15:0] dt,
                           logic [11:0] mx, logic [11:0] my, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.command <= cmd; in_ch.move_dir <= dir;
    in_ch.delta_time <= dt; in_ch.mouse_x <= mx; in_ch.mouse_y <= my;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    board.note_word(cmd, dir, dt, mx, my);
    if (cmd == CMD_LOOK) looks_sent++; else moves_sent++;
  endtask

  // Drop valid and wait for the block to drain before touching registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one register; hold an idle cycle after so writes never collide.
  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, d);
    @(posedge clk);
  endtask

  // Random word: mostly looks and valid moves, some unused directions.
  task automatic random_word(bit gaps);
    logic [2:0] dir;
    logic [15:0] dt;
    logic [11:0] mx, my;
    dir = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    if ($urandom_range(0, 2) == 0) begin
      mx = 12'($urandom); my = 12'($urandom);
    end else begin
      // small mouse motion around the last position
      mx = board.last_x + 12'($urandom_range(0, 40)) - 12'd20;
      my = board.last_y + 12'($urandom_range(0, 40)) - 12'd20;
    end
    send_word(1'($urandom_range(0, 1)), dir, dt, mx, my, gaps);
  endtask

  initial begin
    int phase_words;
    board = new();
    board.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first look records only, moves in every direction at reset values.
    send_word(CMD_MOVE, DIR_FWD, 16'hFFFF, 12'd0, 12'd0, 0);
    send_word(CMD_LOOK, 3'd0, 16'd0, 12'hFFF, 12'h000, 0);
    send_word(CMD_LOOK, 3'd7, 16'hFFFF, 12'h000, 12'hFFF, 0);  // yaw wraps, pitch clamps low
    send_word(CMD_LOOK, 3'd0, 16'd0, 12'h000, 12'h000, 0);     // pitch clamps high
    send_word(CMD_MOVE, DIR_BACK, 16'd1000, 12'hFFF, 12'hFFF, 0);
    send_word(CMD_MOVE, DIR_LEFT, 16'd1000, 12'd0, 12'd0, 0);
    send_word(CMD_MOVE, DIR_RIGHT, 16'd1000, 12'd0, 12'd0, 0);
    send_word(CMD_MOVE, DIR_UP, 16'd1000, 12'd0, 12'd0, 0);
    send_word(CMD_MOVE, DIR_DOWN, 16'd1000, 12'd0, 12'd0, 0);
    send_word(CMD_MOVE, 3'd6, 16'd5, 12'd0, 12'd0, 0);
    send_word(CMD_MOVE, 3'd7, 16'd5, 12'd0, 12'd0, 0);
    drain();

    // Free flight at extreme speed and gain.
    write_reg(REG_MOVE_SPEED, 32'h0000_7FFF);
    write_reg(REG_LOOK_GAIN, 32'h0000_0FFF);
    write_reg(REG_FREE_FLY, 32'd1);
    write_reg(REG_GROUND, 32'h8000_0000);
    for (int i = 0; i < 8; i++)
      send_word(CMD_MOVE, 3'(i % 6), 16'hFFFF, 12'(i * 500), 12'(4095 - i * 500), 0);
    send_word(CMD_LOOK, 3'd0, 16'd0, 12'd7, 12'd4000, 0);
    drain();
    write_reg(REG_MOVE_SPEED, 32'h0000_8000);
    write_reg(REG_GROUND, 32'h7FFF_FFFF);
    write_reg(REG_FREE_FLY, 32'd0);
    write_reg(REG_LOOK_GAIN, 32'd0);
    send_word(CMD_MOVE, DIR_FWD, 16'hFFFF, 12'd0, 12'd0, 0);
    send_word(CMD_LOOK, DIR_FWD, 16'd0, 12'd100, 12'd100, 0);
    drain();

    // Random phases with varied settings; the first includes a long receiver stall.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MOVE_SPEED, (ph == 5) ? 32'h0000_8000 : 32'($urandom));
      write_reg(REG_LOOK_GAIN, (ph == 4) ? 32'hFFF : 32'($urandom_range(0, 200)));
      write_reg(REG_FREE_FLY, 32'(ph % 2));
      write_reg(REG_GROUND, 32'($urandom));
      phase_words = 280;
      for (int i = 0; i < phase_words; i++) begin
        if (ph == 0 && i == 40) hold_off = 1;
        random_word(i % 100 >= 30);
      end
      drain();
    end

    $display("covered %0d look and %0d move words, %0d results checked, six random settings",
             looks_sent, moves_sent, board.matched);
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
hdl/fcou_pkg.sv
hdl/fcou_if.sv
hdl/fcou_mul.sv
hdl/fly_camera_orientation_update.sv
test/fly_camera_orientation_update_test.sv
